### hdl/sh24_pkg.sv
// Package: SipHash-2-4 types, constants and the SipRound function.
package sh24_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned BYTES_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned COMPRESS_ROUNDS_DEF = 2;
    localparam int unsigned FINAL_ROUNDS_DEF    = 4;

    localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } t_sip;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic t_sip sip_round(input t_sip s);
        t_sip t;
        t = s;
        t.v0 = t.v0 + t.v1;
        t.v1 = rotl(t.v1, 13);
        t.v1 = t.v1 ^ t.v0;
        t.v0 = rotl(t.v0, 32);
        t.v2 = t.v2 + t.v3;
        t.v3 = rotl(t.v3, 16);
        t.v3 = t.v3 ^ t.v2;
        t.v0 = t.v0 + t.v3;
        t.v3 = rotl(t.v3, 21);
        t.v3 = t.v3 ^ t.v0;
        t.v2 = t.v2 + t.v1;
        t.v1 = rotl(t.v1, 17);
        t.v1 = t.v1 ^ t.v2;
        t.v2 = rotl(t.v2, 32);
        return t;
    endfunction

    function automatic t_sip key_init(input logic [WORD_W-1:0] k_lo,
                                      input logic [WORD_W-1:0] k_hi);
        t_sip t;
        t.v0 = IV0 ^ k_lo;
        t.v1 = IV1 ^ k_hi;
        t.v2 = IV2 ^ k_lo;
        t.v3 = IV3 ^ k_hi;
        return t;
    endfunction

endpackage

### hdl/sh24_stream_if.sv
// Interfaces: message word channel and hash result channel.
interface sh24_msg_if;
    import sh24_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    message_word;
    logic [COUNT_W-1:0]   byte_count;
    logic                 last_word;

    modport source (output valid, message_word, byte_count, last_word, input ready);
    modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sh24_hash_if;
    import sh24_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

### hdl/siphash_2_4_keyed_hash.sv
// Top level: keyed SipHash-2-4 engine with one shared SipRound unit.
//
// Streams a message as little-endian 64-bit words and returns the 64-bit
// SipHash of it, keyed by the two key registers. A word is taken only while
// the engine is idle (i_msg.ready high); one SipRound unit, applied once per
// cycle under a small sequencer (save while the final round stalls), does
// all the work. A non-last word runs COMPRESS_ROUNDS rounds before the
// engine returns to idle. A last word holding 0 to 7 bytes runs
// COMPRESS_ROUNDS and then FINAL_ROUNDS rounds; a full last word also runs
// an empty final block, holding only the length byte, through COMPRESS_ROUNDS
// rounds. The hash sits in an output register, so the next message may start
// while it waits to be taken; the final round stalls only if a new hash is
// ready while the previous one is still untaken. After each hash the state
// reloads from the key. Writing either key register reloads the state and
// drops any message in progress; write keys only while the engine is idle.
// Byte counts above eight on a last word count as eight; on other words the
// count is ignored and all eight bytes are absorbed.
module siphash_2_4_keyed_hash #(
    parameter int unsigned COMPRESS_ROUNDS = sh24_pkg::COMPRESS_ROUNDS_DEF,
    parameter int unsigned FINAL_ROUNDS    = sh24_pkg::FINAL_ROUNDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sh24_msg_if.sink                          i_msg,
    sh24_hash_if.source                       o_hash,
    input  logic                              i_cfg_we,
    input  logic [sh24_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sh24_pkg::WORD_W-1:0]       i_cfg_data
);
    import sh24_pkg::*;

    localparam int unsigned MAX_ROUNDS =
        (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
    localparam int unsigned CNT_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam logic [CNT_W-1:0] COMP_LAST  = CNT_W'(COMPRESS_ROUNDS - 1);
    localparam logic [CNT_W-1:0] FINAL_LAST = CNT_W'(FINAL_ROUNDS - 1);

    t_state               r_state, n_state;
    t_sip                 r_v, n_v;
    logic [WORD_W-1:0]    r_key_lo, n_key_lo;
    logic [WORD_W-1:0]    r_key_hi, n_key_hi;
    logic [WORD_W-1:0]    r_msg, n_msg;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [CNT_W-1:0]     r_round, n_round;
    logic                 r_final, n_final;     // this word ends the message
    logic                 r_tail, n_tail;       // empty final block still owed
    logic [WORD_W-1:0]    r_hash, n_hash;
    logic                 r_out_valid, n_out_valid;

    logic                 w_accept;
    logic                 w_comp_done;
    logic                 w_fin_done;
    logic                 w_out_free;
    logic                 w_cfg_hit;
    logic                 w_full;
    logic [WORD_W-1:0]    w_block;
    logic [LEN_W-1:0]     w_len_add;
    t_sip                 w_rnd;
    t_sip                 w_t;

    assign w_accept   = i_msg.valid && i_msg.ready;
    assign w_out_free = !r_out_valid || o_hash.ready;
    assign w_cfg_hit  = i_cfg_we && (i_cfg_index inside {REG_KEY_LOW, REG_KEY_HIGH});

    // Shared SipRound unit
    assign w_rnd = sip_round(r_v);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                if (w_comp_done) begin
                    if (!r_final) begin
                        n_state = S_IDLE;
                    end else if (r_tail) begin
                        n_state = S_COMP;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                if (w_fin_done && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_cfg_hit) begin
            n_state = S_IDLE;
        end
    end

    // Sequencer outputs
    always_comb begin
        i_msg.ready = 1'b0;
        w_comp_done = 1'b0;
        w_fin_done  = 1'b0;
        case (r_state)
            S_IDLE:  i_msg.ready = 1'b1;
            S_COMP:  w_comp_done = (r_round == COMP_LAST);
            S_FINAL: w_fin_done  = (r_round == FINAL_LAST);
            default: i_msg.ready = 1'b0;
        endcase
    end

    // Build the block for an incoming word: full word, or the masked tail
    // bytes with the running length in the top byte.
    always_comb begin
        w_full    = !i_msg.last_word || (i_msg.byte_count >= FULL_COUNT);
        w_len_add = w_full ? LEN_W'(BYTES_W) : LEN_W'(i_msg.byte_count);
        w_block   = '0;
        if (w_full) begin
            w_block = i_msg.message_word;
        end else begin
            for (int b = 0; b < BYTES_W; b++) begin
                if (COUNT_W'(b) < i_msg.byte_count) begin
                    w_block[8*b +: 8] = i_msg.message_word[8*b +: 8];
                end
            end
            w_block[WORD_W-1 -: LEN_W] = r_len + w_len_add;
        end
    end

    // Datapath
    always_comb begin
        n_v         = r_v;
        n_key_lo    = r_key_lo;
        n_key_hi    = r_key_hi;
        n_msg       = r_msg;
        n_len       = r_len;
        n_round     = r_round;
        n_final     = r_final;
        n_tail      = r_tail;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !o_hash.ready;
        w_t         = w_rnd;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_v.v3  = r_v.v3 ^ w_block;
                    n_msg   = w_block;
                    n_len   = r_len + w_len_add;
                    n_final = i_msg.last_word;
                    n_tail  = i_msg.last_word && w_full;
                    n_round = '0;
                end
            end
            S_COMP: begin
                n_round = r_round + 1'b1;
                if (w_comp_done) begin
                    w_t.v0  = w_rnd.v0 ^ r_msg;
                    n_round = '0;
                    if (r_final && r_tail) begin
                        // absorb the empty final block: length byte only
                        n_msg  = {r_len, {(WORD_W-LEN_W){1'b0}}};
                        w_t.v3 = w_t.v3 ^ n_msg;
                        n_tail = 1'b0;
                    end else if (r_final) begin
                        w_t.v2 = w_t.v2 ^ FINAL_MARK;
                    end
                end
                n_v = w_t;
            end
            S_FINAL: begin
                if (!w_fin_done) begin
                    n_v     = w_rnd;
                    n_round = r_round + 1'b1;
                end else if (w_out_free) begin
                    n_hash      = w_rnd.v0 ^ w_rnd.v1 ^ w_rnd.v2 ^ w_rnd.v3;
                    n_out_valid = 1'b1;
                    n_v         = key_init(r_key_lo, r_key_hi);
                    n_len       = '0;
                    n_round     = '0;
                end
            end
            default: n_round = '0;
        endcase

        // Key write: update the register and reload the state
        if (i_cfg_we && (i_cfg_index == REG_KEY_LOW)) begin
            n_key_lo = i_cfg_data;
        end
        if (i_cfg_we && (i_cfg_index == REG_KEY_HIGH)) begin
            n_key_hi = i_cfg_data;
        end
        if (w_cfg_hit) begin
            n_v     = key_init(n_key_lo, n_key_hi);
            n_len   = '0;
            n_round = '0;
            n_final = 1'b0;
            n_tail  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v         <= key_init('0, '0);
            r_key_lo    <= '0;
            r_key_hi    <= '0;
            r_len       <= '0;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_tail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v         <= n_v;
            r_key_lo    <= n_key_lo;
            r_key_hi    <= n_key_hi;
            r_len       <= n_len;
            r_round     <= n_round;
            r_final     <= n_final;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_msg  <= n_msg;
        r_hash <= n_hash;
    end

    assign o_hash.valid      = r_out_valid;
    assign o_hash.hash_value = r_hash;

endmodule
